// ----- rtl/core/murmur3_key_bucket_select_macros.svh -----
// Assertion macros for the murmur3 key bucket select block.
// Taken in by the top level with an include; no other dependencies.
`ifndef MURMUR3_KEY_BUCKET_SELECT_MACROS_SVH
`define MURMUR3_KEY_BUCKET_SELECT_MACROS_SVH

`ifndef ASSERT_OFF

// Antecedent implies consequent in the same cycle
`define MKBS_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mkbs assertion failed");

// Antecedent implies consequent in the next cycle
`define MKBS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mkbs assertion failed");

`else

`define MKBS_ASSERT_SAME(label, clk, rstn, ante, cons)
`define MKBS_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ----- rtl/core/mkbs_pkg.sv -----
// Shared types and constants for the murmur3 key bucket select block.
// Used by mkbs_ctrl, mkbs_dp and the top level; no dependencies.
package mkbs_pkg;

    // Field widths
    localparam int KEY_W    = 8;
    localparam int BUCKET_W = 27;
    localparam int HASH_W   = 32;

    // MurmurHash3 x86_32 constants
    localparam logic [HASH_W-1:0] SEED     = 32'h0000_0000;
    localparam logic [HASH_W-1:0] MM_C1    = 32'hcc9e_2d51;
    localparam logic [HASH_W-1:0] MM_C2    = 32'h1b87_3593;
    localparam logic [HASH_W-1:0] MM_HADD  = 32'he654_6b64;
    localparam logic [HASH_W-1:0] MM_FMIX1 = 32'h85eb_ca6b;
    localparam logic [HASH_W-1:0] MM_FMIX2 = 32'hc2b2_ae35;

    // Datapath operation codes
    localparam logic [3:0] OP_NONE   = 4'd0;
    localparam logic [3:0] OP_ACCEPT = 4'd1;  // absorb one input beat
    localparam logic [3:0] OP_K1     = 4'd2;  // w = w * C1
    localparam logic [3:0] OP_K2     = 4'd3;  // w = rotl(w,15) * C2
    localparam logic [3:0] OP_HMIX   = 4'd4;  // fold scrambled block into h
    localparam logic [3:0] OP_TLOAD  = 4'd5;  // w = tail bytes
    localparam logic [3:0] OP_TXOR   = 4'd6;  // h ^= scrambled tail
    localparam logic [3:0] OP_FIN1   = 4'd7;  // length fold, first avalanche multiply
    localparam logic [3:0] OP_FIN2   = 4'd8;  // second avalanche multiply
    localparam logic [3:0] OP_FIN3   = 4'd9;  // last xor-shift, set up division
    localparam logic [3:0] OP_DIV    = 4'd10; // one restoring division step
    localparam logic [3:0] OP_OUT    = 4'd11; // load result, clear key state

    typedef struct packed {
        logic [3:0] op;
    } cmd_t;

    typedef struct packed {
        logic pend_full;  // three bytes waiting: next byte completes a block
        logic pend_any;   // at least one tail byte waiting
    } stat_t;

endpackage

// ----- rtl/core/murmur3_key_bucket_select.sv -----
// Top level of the murmur3 key bucket select block.
// Depends on mkbs_pkg, mkbs_ctrl, mkbs_dp and the assertion macro header.
//
//   channel  direction  handshake            payload
//   s_       in         s_valid / s_ready    s_key_byte, s_byte_present, s_key_end
//   m_       out        m_valid / m_ready    m_bucket_index, m_hash_value
//   cfg_     in         cfg_valid/cfg_ready  cfg_data (bucket count)
//
// A byte that does not complete a four-byte block is only absorbed; one that
// completes a block also takes two passes through the shared multiplier, then mix.
// A key end beat runs the accept, then block, tail and final mix, the bit-serial
// divider and the load of the result register.
// Reset is synchronous, active low; bucket count resets to 1.
// A held result beat stalls nothing until the next result is ready to load;
// the block then waits, input included, until the result register drains.
`include "murmur3_key_bucket_select_macros.svh"

module murmur3_key_bucket_select (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [mkbs_pkg::KEY_W-1:0]      s_key_byte,
    input  logic                            s_byte_present,
    input  logic                            s_key_end,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [mkbs_pkg::BUCKET_W-1:0]   m_bucket_index,
    output logic [mkbs_pkg::HASH_W-1:0]     m_hash_value,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mkbs_pkg::BUCKET_W-1:0]   cfg_data
);

    mkbs_pkg::cmd_t  cmd;
    mkbs_pkg::stat_t stat;

    // configuration is always taken
    assign cfg_ready = 1'b1;

    mkbs_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_byte_present (s_byte_present),
        .s_key_end      (s_key_end),
        .s_ready        (s_ready),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .stat           (stat),
        .cmd            (cmd)
    );

    mkbs_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_key_byte     (s_key_byte),
        .s_byte_present (s_byte_present),
        .cfg_valid      (cfg_valid),
        .cfg_data       (cfg_data),
        .m_bucket_index (m_bucket_index),
        .m_hash_value   (m_hash_value)
    );

    // key end beat always starts a busy finalisation
    `MKBS_ASSERT_NEXT(a_end_busy, aclk, aresetn, s_valid && s_ready && s_key_end, !s_ready)
    // result is loaded only into a free or draining output register
    `MKBS_ASSERT_SAME(a_out_free, aclk, aresetn, cmd.op == mkbs_pkg::OP_OUT, !m_valid || m_ready)
    // a new result beat follows a busy cycle
    `MKBS_ASSERT_SAME(a_rise_busy, aclk, aresetn, $rose(m_valid), $past(!s_ready))

endmodule

// ----- rtl/core/mkbs_ctrl.sv -----
// Sequencer for the murmur3 key bucket select block.
// Depends on mkbs_pkg; drives the datapath through mkbs_pkg::cmd_t.
module mkbs_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    input  logic           s_byte_present,
    input  logic           s_key_end,
    output logic           s_ready,
    input  logic           m_ready,
    output logic           m_valid,
    input  mkbs_pkg::stat_t stat,
    output mkbs_pkg::cmd_t  cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_K1   = 4'd1;
    localparam logic [3:0] S_K2   = 4'd2;
    localparam logic [3:0] S_HMIX = 4'd3;
    localparam logic [3:0] S_TAIL = 4'd4;
    localparam logic [3:0] S_T1   = 4'd5;
    localparam logic [3:0] S_T2   = 4'd6;
    localparam logic [3:0] S_TXOR = 4'd7;
    localparam logic [3:0] S_FIN1 = 4'd8;
    localparam logic [3:0] S_FIN2 = 4'd9;
    localparam logic [3:0] S_FIN3 = 4'd10;
    localparam logic [3:0] S_DIV  = 4'd11;
    localparam logic [3:0] S_OUT  = 4'd12;

    logic [3:0] state_reg, state_next;
    logic       last_reg, last_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    // Next state and command
    always_comb begin
        state_next   = state_reg;
        last_next    = last_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        cmd.op       = mkbs_pkg::OP_NONE;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op    = mkbs_pkg::OP_ACCEPT;
                    last_next = s_key_end;
                    if (s_byte_present && stat.pend_full) begin
                        state_next = S_K1;
                    end else if (s_key_end) begin
                        state_next = S_TAIL;
                    end
                end
            end
            S_K1: begin
                cmd.op     = mkbs_pkg::OP_K1;
                state_next = S_K2;
            end
            S_K2: begin
                cmd.op     = mkbs_pkg::OP_K2;
                state_next = S_HMIX;
            end
            S_HMIX: begin
                cmd.op     = mkbs_pkg::OP_HMIX;
                state_next = last_reg ? S_TAIL : S_IDLE;
            end
            S_TAIL: begin
                if (stat.pend_any) begin
                    cmd.op     = mkbs_pkg::OP_TLOAD;
                    state_next = S_T1;
                end else begin
                    state_next = S_FIN1;
                end
            end
            S_T1: begin
                cmd.op     = mkbs_pkg::OP_K1;
                state_next = S_T2;
            end
            S_T2: begin
                cmd.op     = mkbs_pkg::OP_K2;
                state_next = S_TXOR;
            end
            S_TXOR: begin
                cmd.op     = mkbs_pkg::OP_TXOR;
                state_next = S_FIN1;
            end
            S_FIN1: begin
                cmd.op     = mkbs_pkg::OP_FIN1;
                state_next = S_FIN2;
            end
            S_FIN2: begin
                cmd.op     = mkbs_pkg::OP_FIN2;
                state_next = S_FIN3;
            end
            S_FIN3: begin
                cmd.op     = mkbs_pkg::OP_FIN3;
                cnt_next   = '1;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.op   = mkbs_pkg::OP_DIV;
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == '0) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                // wait for the output register to drain
                if (!m_valid_reg || m_ready) begin
                    cmd.op       = mkbs_pkg::OP_OUT;
                    m_valid_next = 1'b1;
                    last_next    = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            last_reg    <= 1'b0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            last_reg    <= last_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ----- rtl/core/mkbs_dp.sv -----
// Datapath for the murmur3 key bucket select block: hash state, shared
// multiplier, restoring divider and result register. Depends on mkbs_pkg.
module mkbs_dp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  mkbs_pkg::cmd_t                  cmd,
    output mkbs_pkg::stat_t                 stat,
    input  logic [mkbs_pkg::KEY_W-1:0]      s_key_byte,
    input  logic                            s_byte_present,
    input  logic                            cfg_valid,
    input  logic [mkbs_pkg::BUCKET_W-1:0]   cfg_data,
    output logic [mkbs_pkg::BUCKET_W-1:0]   m_bucket_index,
    output logic [mkbs_pkg::HASH_W-1:0]     m_hash_value
);

    localparam int BW = mkbs_pkg::BUCKET_W;
    localparam int HW = mkbs_pkg::HASH_W;

    logic [HW-1:0] h_reg, h_next;
    logic [HW-1:0] w_reg, w_next;
    logic [23:0]   pend_reg, pend_next;
    logic [1:0]    pcnt_reg, pcnt_next;
    logic [HW-1:0] len_reg, len_next;
    logic [BW-1:0] bucket_reg;
    logic [HW-1:0] mag_reg, mag_next;
    logic [BW-1:0] rem_reg, rem_next;
    logic          neg_reg, neg_next;
    logic [BW-1:0] idx_out_reg, idx_out_next;
    logic [HW-1:0] hash_out_reg, hash_out_next;

    logic [HW-1:0] mul_a, mul_b, mul_p;
    logic [HW-1:0] fin1_x, fin2_x, fin3_x, hmix_x, hmix_r;
    logic [BW-1:0] mod_m;
    logic [BW:0]   trial;

    assign stat.pend_full = (pcnt_reg == 2'd3);
    assign stat.pend_any  = (pcnt_reg != 2'd0);
    assign m_bucket_index = idx_out_reg;
    assign m_hash_value   = hash_out_reg;

    // a zero bucket count acts as one
    assign mod_m = (bucket_reg == '0) ? BW'(1) : bucket_reg;

    // mixing terms
    assign fin1_x = (h_reg ^ len_reg) ^ ((h_reg ^ len_reg) >> 16);
    assign fin2_x = w_reg ^ (w_reg >> 13);
    assign fin3_x = w_reg ^ (w_reg >> 16);
    assign hmix_x = h_reg ^ w_reg;
    assign hmix_r = {hmix_x[18:0], hmix_x[31:19]};
    assign trial  = {rem_reg, mag_reg[HW-1]};

    // shared multiplier, low word only
    always_comb begin
        case (cmd.op)
            mkbs_pkg::OP_K1: begin
                mul_a = w_reg;
                mul_b = mkbs_pkg::MM_C1;
            end
            mkbs_pkg::OP_K2: begin
                mul_a = {w_reg[16:0], w_reg[31:17]};
                mul_b = mkbs_pkg::MM_C2;
            end
            mkbs_pkg::OP_FIN1: begin
                mul_a = fin1_x;
                mul_b = mkbs_pkg::MM_FMIX1;
            end
            default: begin
                mul_a = fin2_x;
                mul_b = mkbs_pkg::MM_FMIX2;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // next values per operation
    always_comb begin
        h_next        = h_reg;
        w_next        = w_reg;
        pend_next     = pend_reg;
        pcnt_next     = pcnt_reg;
        len_next      = len_reg;
        mag_next      = mag_reg;
        rem_next      = rem_reg;
        neg_next      = neg_reg;
        idx_out_next  = idx_out_reg;
        hash_out_next = hash_out_reg;
        case (cmd.op)
            mkbs_pkg::OP_ACCEPT: begin
                if (s_byte_present) begin
                    len_next = len_reg + HW'(1);
                    case (pcnt_reg)
                        2'd0: pend_next[7:0]   = s_key_byte;
                        2'd1: pend_next[15:8]  = s_key_byte;
                        2'd2: pend_next[23:16] = s_key_byte;
                        default: begin
                            // block complete, hand it to the scrambler
                            w_next    = {s_key_byte, pend_reg};
                            pend_next = '0;
                        end
                    endcase
                    pcnt_next = pcnt_reg + 2'd1;
                end
            end
            mkbs_pkg::OP_K1,
            mkbs_pkg::OP_K2,
            mkbs_pkg::OP_FIN1,
            mkbs_pkg::OP_FIN2: begin
                w_next = mul_p;
            end
            mkbs_pkg::OP_HMIX: begin
                h_next = (hmix_r << 2) + hmix_r + mkbs_pkg::MM_HADD;
            end
            mkbs_pkg::OP_TLOAD: begin
                w_next = {8'h00, pend_reg};
            end
            mkbs_pkg::OP_TXOR: begin
                h_next = h_reg ^ w_reg;
            end
            mkbs_pkg::OP_FIN3: begin
                w_next   = fin3_x;
                neg_next = fin3_x[HW-1];
                mag_next = fin3_x[HW-1] ? (HW'(0) - fin3_x) : fin3_x;
                rem_next = '0;
            end
            mkbs_pkg::OP_DIV: begin
                // remainder stays below the modulus, so trial fits BW+1 bits
                if (trial >= {1'b0, mod_m}) begin
                    rem_next = BW'(trial - {1'b0, mod_m});
                end else begin
                    rem_next = trial[BW-1:0];
                end
                mag_next = {mag_reg[HW-2:0], 1'b0};
            end
            mkbs_pkg::OP_OUT: begin
                idx_out_next  = (neg_reg && rem_reg != '0) ? (mod_m - rem_reg) : rem_reg;
                hash_out_next = w_reg;
                h_next        = mkbs_pkg::SEED;
                pend_next     = '0;
                pcnt_next     = '0;
                len_next      = '0;
            end
            default: begin
                h_next = h_reg;
            end
        endcase
    end

    // key state and bucket count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_reg      <= mkbs_pkg::SEED;
            pend_reg   <= '0;
            pcnt_reg   <= '0;
            len_reg    <= '0;
            bucket_reg <= BW'(1);
        end else begin
            h_reg    <= h_next;
            pend_reg <= pend_next;
            pcnt_reg <= pcnt_next;
            len_reg  <= len_next;
            if (cfg_valid) begin
                bucket_reg <= cfg_data;
            end
        end
    end

    // working and result payload
    always_ff @(posedge aclk) begin
        w_reg        <= w_next;
        mag_reg      <= mag_next;
        rem_reg      <= rem_next;
        neg_reg      <= neg_next;
        idx_out_reg  <= idx_out_next;
        hash_out_reg <= hash_out_next;
    end

endmodule

// ----- bench/testbench.sv -----
// Testbench for murmur3_key_bucket_select: keys go in byte by byte, results come out.
// Each result is checked against a bit-exact MurmurHash3 x86_32 predictor with bucket reduction.
// Depends on mkbs_pkg and the murmur3_key_bucket_select RTL only.
module testbench;
    import mkbs_pkg::*;

    localparam int     CLK_HALF      = 5;
    localparam int     RESET_CYCLES  = 8;
    localparam int     SETTLE_CYCLES = 64;     // covers the key end latency
    localparam longint CYCLE_LIMIT   = 1000000;
    localparam int     RANDOM_ITEMS  = 1000;
    localparam logic [BUCKET_W-1:0] BUCKET_MAX = '1;

    typedef struct packed {
        logic [BUCKET_W-1:0] bucket_index;
        logic [HASH_W-1:0]   hash_value;
    } bucket_result_t;

    typedef logic [KEY_W-1:0] key_bytes_t [$];

    // DUT connections; the inputs are driven to known values from time zero
    logic                aclk           = 1'b0;
    logic                aresetn        = 1'b0;
    logic                s_valid        = 1'b0;
    logic                s_ready;
    logic [KEY_W-1:0]    s_key_byte     = '0;
    logic                s_byte_present = 1'b0;
    logic                s_key_end      = 1'b0;
    logic                m_valid;
    logic                m_ready        = 1'b0;
    logic [BUCKET_W-1:0] m_bucket_index;
    logic [HASH_W-1:0]   m_hash_value;
    logic                cfg_valid      = 1'b0;
    logic                cfg_ready;
    logic [BUCKET_W-1:0] cfg_data       = '0;

    // predicted hashing state, mirrors the block after reset
    logic [HASH_W-1:0]   run_hash       = SEED;
    logic [23:0]         tail_bytes     = '0;
    logic [1:0]          tail_count     = '0;
    logic [31:0]         key_len        = '0;
    logic [BUCKET_W-1:0] bucket_setting = BUCKET_W'(1);

    bucket_result_t hash_results [$];

    // traffic shaping
    bit     no_gaps     = 1'b0;
    bit     heavy_stall = 1'b0;
    int     rx_stall    = 0;

    // bookkeeping
    longint cycle_count   = 0;
    int     fail_count    = 0;
    int     results_seen  = 0;
    int     keys_finished = 0;
    int     live_items    = 0;
    int     idle_items    = 0;
    int     config_writes = 0;

    murmur3_key_bucket_select uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_key_byte     (s_key_byte),
        .s_byte_present (s_byte_present),
        .s_key_end      (s_key_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_bucket_index (m_bucket_index),
        .m_hash_value   (m_hash_value),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    // clock
    always begin
        #(CLK_HALF) aclk = 1'b1;
        #(CLK_HALF) aclk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [31:0] scramble_block(input logic [31:0] k);
        logic [31:0] t;
        t = k * MM_C1;
        t = {t[16:0], t[31:17]};    // rotate left 15
        return t * MM_C2;
    endfunction

    function automatic logic [31:0] final_mix(input logic [31:0] h);
        logic [31:0] t;
        t = h ^ (h >> 16);
        t = t * MM_FMIX1;
        t = t ^ (t >> 13);
        t = t * MM_FMIX2;
        return t ^ (t >> 16);
    endfunction

    // Absorbs one accepted beat; returns 1 with the expected result on a key end.
    function automatic bit absorb_key_item(input logic [KEY_W-1:0] b, input bit present,
                                           input bit last, output bucket_result_t res);
        logic [31:0] h;
        logic [31:0] modulus;
        logic [31:0] mag;
        logic [31:0] rem;
        res = '0;
        if (present) begin
            key_len = key_len + 32'd1;
            if (tail_count == 2'd3) begin
                // fourth byte completes a little-endian block
                h = run_hash ^ scramble_block({b, tail_bytes});
                h = {h[18:0], h[31:19]};
                run_hash = h * 32'd5 + MM_HADD;
                tail_bytes = '0;
                tail_count = '0;
            end else begin
                tail_bytes = tail_bytes | (24'(b) << (8 * tail_count));
                tail_count = tail_count + 2'd1;
            end
        end
        if (!last)
            return 1'b0;

        // tail, length fold and avalanche
        h = run_hash;
        if (tail_count != 2'd0)
            h = h ^ scramble_block({8'h00, tail_bytes});
        h = final_mix(h ^ key_len);

        // signed hash, floored modulo; a zero bucket count behaves as one
        modulus = (bucket_setting == '0) ? 32'd1 : 32'(bucket_setting);
        mag = h[31] ? -h : h;
        rem = mag % modulus;
        res.bucket_index = BUCKET_W'((h[31] && rem != 32'd0) ? modulus - rem : rem);
        res.hash_value = h;

        run_hash = SEED;
        tail_bytes = '0;
        tail_count = '0;
        key_len = '0;
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------- shared helpers

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_key_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 0;
        if (r < 70)
            return $urandom_range(1, 8);
        if (r < 92)
            return $urandom_range(9, 16);
        return $urandom_range(17, 48);
    endfunction

    function automatic key_bytes_t random_key(input int len);
        key_bytes_t q;
        for (int i = 0; i < len; i++)
            q.push_back(8'($urandom_range(0, 255)));
        return q;
    endfunction

    // One input beat; valid is only dropped when a gap is taken
    task automatic send_beat(input logic [KEY_W-1:0] b, input bit present, input bit last);
        int gap;
        bucket_result_t res;
        gap = no_gaps ? 0 : pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_key_byte     <= b;
        s_byte_present <= present;
        s_key_end      <= last;
        do @(posedge aclk); while (!s_ready);
        if (absorb_key_item(b, present, last, res)) begin
            hash_results.push_back(res);
            keys_finished++;
        end
        if (present || last)
            live_items++;
        else
            idle_items++;
    endtask

    // A whole key; the end flag rides on the last byte or on a separate empty beat
    task automatic send_key(input key_bytes_t bytes, input bit end_on_byte, input int idle_pct);
        int n;
        n = bytes.size();
        for (int i = 0; i < n; i++) begin
            if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
                send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_beat(bytes[i], 1'b1, end_on_byte && (i == n - 1));
        end
        if (n == 0 || !end_on_byte)
            send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // Sender goes quiet until every predicted result has been seen
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (hash_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_bucket_count(input logic [BUCKET_W-1:0] count);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= count;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        bucket_setting = count;
        config_writes++;
        @(posedge aclk);
    endtask

    // ---------------------------------------------------------------- tests

    // bucket count of one straight out of reset: empty key, idle beat, single byte
    task automatic test_reset_count();
        send_key(random_key(0), 1'b0, 0);
        send_beat(8'hA5, 1'b0, 1'b0);
        send_key('{8'h00}, 1'b1, 0);
    endtask

    // byte extremes, tails of every length, exact blocks, idle beats inside a key
    task automatic test_directed_keys();
        send_key('{8'hFF, 8'hFF, 8'hFF}, 1'b0, 0);
        send_key('{8'h00, 8'hFF, 8'h80, 8'h7F}, 1'b1, 0);
        send_beat(8'h01, 1'b1, 1'b0);
        send_beat(8'h02, 1'b1, 1'b0);
        send_beat(8'hFF, 1'b0, 1'b0);
        send_beat(8'h03, 1'b1, 1'b0);
        send_beat(8'h04, 1'b1, 1'b0);
        send_beat(8'h05, 1'b1, 1'b1);
        send_key('{8'h55, 8'hAA}, 1'b1, 0);
        send_key('{8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67}, 1'b0, 0);
    endtask

    // zero count, the 27-bit maximum, top of the stated range and the smallest real modulus
    task automatic test_bucket_extremes();
        logic [BUCKET_W-1:0] counts [4];
        counts = '{'0, BUCKET_MAX, 27'd99999999, 27'd2};
        foreach (counts[i]) begin
            write_bucket_count(counts[i]);
            repeat (6)
                send_key(random_key(pick_key_len()), 1'($urandom_range(0, 1)), 0);
        end
    endtask

    // bulk random keys across a spread of bucket counts, two phases without gaps
    task automatic test_random_keys();
        logic [BUCKET_W-1:0] counts [10];
        int phase_start;
        counts = '{27'($urandom_range(1, 99999999)), 27'd3, 27'd7, 27'd1000, 27'd65536,
                   27'($urandom_range(0, 32'h7FFFFFF)), 27'd1, 27'd99999999, '0,
                   27'($urandom_range(1, 16))};
        foreach (counts[p]) begin
            write_bucket_count(counts[p]);
            no_gaps = (p == 3 || p == 7);
            phase_start = live_items;
            while (live_items - phase_start < RANDOM_ITEMS / 10)
                send_key(random_key(pick_key_len()), 1'($urandom_range(0, 1)), 5);
        end
        no_gaps = 1'b0;
    endtask

    // long receiver stalls, with a full drain halfway through
    task automatic test_result_stalls();
        write_bucket_count(27'd12345);
        heavy_stall = 1'b1;
        repeat (10)
            send_key(random_key(pick_key_len()), 1'($urandom_range(0, 1)), 0);
        drain_results();
        repeat (10)
            send_key(random_key($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 0);
        drain_results();
        heavy_stall = 1'b0;
    endtask

    // ---------------------------------------------------------------- receiver and checks

    // result side ready, with random stalls
    always @(posedge aclk) begin
        if (rx_stall != 0) begin
            m_ready  <= 1'b0;
            rx_stall <= rx_stall - 1;
        end else begin
            m_ready <= 1'b1;
            if (!no_gaps && $urandom_range(0, 3) == 0)
                rx_stall <= heavy_stall ? $urandom_range(20, 80) : pick_gap();
        end
    end

    // compare every result beat with the oldest prediction
    always @(posedge aclk) begin : check_results
        bucket_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (hash_results.size() == 0) begin
                $display("%0t: result beat with nothing expected: bucket_index %0d hash_value %h",
                         $time, m_bucket_index, m_hash_value);
                fail_count++;
            end else begin
                want = hash_results.pop_front();
                results_seen++;
                if (m_bucket_index !== want.bucket_index) begin
                    $display("%0t: bucket_index expected %0d actual %0d",
                             $time, want.bucket_index, m_bucket_index);
                    fail_count++;
                end
                if (m_hash_value !== want.hash_value) begin
                    $display("%0t: hash_value expected %h actual %h",
                             $time, want.hash_value, m_hash_value);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d results outstanding", $time, hash_results.size());
            $display("simulation failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_count();
        test_directed_keys();
        test_bucket_extremes();
        test_random_keys();
        test_result_stalls();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("%0d keys hashed from %0d key beats and %0d idle beats, %0d results compared",
                 keys_finished, live_items, idle_items, results_seen);
        $display("%0d bucket count settings, zero and the 27-bit maximum among them",
                 config_writes);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
